// ===== rtl/core/mse_pkg.sv =====
// ----------------------------------------------------------------------------
// mse_pkg
// Shared types and constants of the MIPS32 subset executor: opcodes,
// function codes, status codes and the execute result record.
// ----------------------------------------------------------------------------
package mse_pkg;

  localparam int unsigned MEM_WORDS_DEF = 16384;
  localparam logic [31:0] PC_RESET      = 32'h0000_1000;
  localparam logic [31:0] PC_REGION     = 32'hf000_0000;

  // Primary opcodes
  localparam logic [5:0] OP_SPECIAL = 6'h00;
  localparam logic [5:0] OP_J       = 6'h02;
  localparam logic [5:0] OP_JAL     = 6'h03;
  localparam logic [5:0] OP_BEQ     = 6'h04;
  localparam logic [5:0] OP_BNE     = 6'h05;
  localparam logic [5:0] OP_ADDIU   = 6'h09;
  localparam logic [5:0] OP_SLTI    = 6'h0a;
  localparam logic [5:0] OP_SLTIU   = 6'h0b;
  localparam logic [5:0] OP_ANDI    = 6'h0c;
  localparam logic [5:0] OP_ORI     = 6'h0d;
  localparam logic [5:0] OP_XORI    = 6'h0e;
  localparam logic [5:0] OP_LUI     = 6'h0f;
  localparam logic [5:0] OP_LB      = 6'h20;
  localparam logic [5:0] OP_LW      = 6'h23;
  localparam logic [5:0] OP_LBU     = 6'h24;
  localparam logic [5:0] OP_SB      = 6'h28;
  localparam logic [5:0] OP_SW      = 6'h2b;

  // SPECIAL function codes
  localparam logic [5:0] FN_SLL     = 6'h00;
  localparam logic [5:0] FN_SRL     = 6'h02;
  localparam logic [5:0] FN_SRA     = 6'h03;
  localparam logic [5:0] FN_JR      = 6'h08;
  localparam logic [5:0] FN_JALR    = 6'h09;
  localparam logic [5:0] FN_SYSCALL = 6'h0c;
  localparam logic [5:0] FN_MFHI    = 6'h10;
  localparam logic [5:0] FN_MFLO    = 6'h12;
  localparam logic [5:0] FN_MULT    = 6'h18;
  localparam logic [5:0] FN_ADDU    = 6'h21;
  localparam logic [5:0] FN_SUBU    = 6'h23;
  localparam logic [5:0] FN_AND     = 6'h24;
  localparam logic [5:0] FN_OR      = 6'h25;
  localparam logic [5:0] FN_XOR     = 6'h26;
  localparam logic [5:0] FN_NOR     = 6'h27;
  localparam logic [5:0] FN_SLT     = 6'h2a;
  localparam logic [5:0] FN_SLTU    = 6'h2b;

  // Transaction input kinds
  localparam logic OPER_EXEC = 1'b0;
  localparam logic OPER_LOAD = 1'b1;

  // Status codes
  localparam logic [1:0] ST_NORMAL  = 2'd0;
  localparam logic [1:0] ST_SYSCALL = 2'd1;
  localparam logic [1:0] ST_ILLEGAL = 2'd2;

  typedef enum logic [1:0] {
    LD_NONE,
    LD_LB,
    LD_LBU,
    LD_LW
  } ld_kind_e;

  typedef struct packed {
    logic [31:0] npc;
    logic [1:0]  status;
    logic [31:0] sc_code;
    logic [31:0] sc_arg;
    logic        wr;        // destination written, never r0
    logic [4:0]  idx;
    logic [31:0] val;       // non-load result
    ld_kind_e    ld;
    logic        st;
    logic        st_byte;
    logic [31:0] st_addr;
    logic [31:0] st_val;
    logic        hilo_we;
    logic [31:0] hi;
    logic [31:0] lo;
  } exec_res_t;

endpackage

// ===== rtl/core/mips32_subset_executor.sv =====
// ----------------------------------------------------------------------------
// mips32_subset_executor
// Executes one MIPS32 subset instruction, or one loader word write, per
// transaction; holds the register file, hi/lo, pc and the data memory.
// ----------------------------------------------------------------------------
// Stages: operand capture, then execute and memory access into the output register.
// Throughput: one transaction per cycle while the output is free or taken; a
//   load in the operand stage stalls the next instruction when its rs or rt
//   field names the loaded register, or when the load writes r2 or r4.
// Reset: rst_ni clears registers, hi, lo and pc (to 0x1000) at once; data
//   memory has no reset and needs no clearing pass. MEM_WORDS is a power of 2.
module mips32_subset_executor #(
  parameter int unsigned MEM_WORDS = mse_pkg::MEM_WORDS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // word [31:0], load_address [47:32]
  input  logic [47:0]  s_axis_tdata,
  // operation [0]
  input  logic         s_axis_tuser,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // next_pc [31:0], status [33:32], syscall_code [65:34], syscall_arg [97:66],
  // reg_written [98], reg_index [103:99], reg_value [135:104], stored [136],
  // store_address [168:137], store_value [200:169], store_is_byte [201],
  // zero fill [207:202]
  output logic [207:0] m_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready
);

  localparam int unsigned AW = $clog2(MEM_WORDS);

  // Input fields
  logic        in_op;
  logic [31:0] in_word;
  logic [15:0] in_laddr;
  logic [4:0]  in_rs;
  logic [4:0]  in_rt;

  assign in_op    = s_axis_tuser;
  assign in_word  = s_axis_tdata[31:0];
  assign in_laddr = s_axis_tdata[47:32];
  assign in_rs    = in_word[25:21];
  assign in_rt    = in_word[20:16];

  // Architectural state
  logic [31:0] regs_q [32];
  logic [31:0] hi_q, lo_q, pc_q;
  logic [3:0][7:0] mem [MEM_WORDS];
  logic [31:0] rdata_q;

  // Operand stage
  logic        s1_valid_q;
  logic        s1_op_q;
  logic [31:0] s1_word_q;
  logic [15:0] s1_laddr_q;
  logic [31:0] s1_a_q, s1_b_q, s1_r2_q, s1_r4_q;

  // Output stage
  logic        out_valid_q;
  logic [31:0] out_npc_q;
  logic [1:0]  out_status_q;
  logic [31:0] out_sc_code_q, out_sc_arg_q;
  logic        out_wr_q;
  logic [4:0]  out_idx_q;
  logic [31:0] out_val_q;
  mse_pkg::ld_kind_e out_ld_q;
  logic [1:0]  out_lane_q;
  logic        out_st_q;
  logic [31:0] out_st_addr_q, out_st_val_q;
  logic        out_st_byte_q;
  logic        ldpend_q;

  mse_pkg::exec_res_t ex;
  logic        advance, s1_fire, s_accept, hazard, s1_exec;
  logic        wa_en, wb_en;
  logic [31:0] load_val;
  logic [7:0]  load_byte;
  logic [31:0] ldaddr_ext;
  logic [AW-1:0] ld_idx, ea_idx;

  mse_exec u_exec (
    .instr_i (s1_word_q),
    .pc_i    (pc_q),
    .a_i     (s1_a_q),
    .b_i     (s1_b_q),
    .r2_i    (s1_r2_q),
    .r4_i    (s1_r4_q),
    .hi_i    (hi_q),
    .lo_i    (lo_q),
    .res_o   (ex)
  );

  // Advance both stages whenever the output register is free or taken.
  assign advance  = !out_valid_q || m_axis_tready;
  assign s1_fire  = s1_valid_q && advance;
  assign s1_exec  = s1_valid_q && (s1_op_q == mse_pkg::OPER_EXEC);

  // Stall an instruction that reads a register still being loaded.
  assign hazard = s1_exec && (ex.ld != mse_pkg::LD_NONE) && (in_op == mse_pkg::OPER_EXEC) &&
                  (ex.idx == in_rs || ex.idx == in_rt || ex.idx == 5'd2 || ex.idx == 5'd4);

  assign s_axis_tready = advance && !hazard;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  // Load result formatting from the registered memory word
  always_comb begin
    case (out_lane_q)
      2'd0:    load_byte = rdata_q[7:0];
      2'd1:    load_byte = rdata_q[15:8];
      2'd2:    load_byte = rdata_q[23:16];
      default: load_byte = rdata_q[31:24];
    endcase
    case (out_ld_q)
      mse_pkg::LD_LB:  load_val = {{24{load_byte[7]}}, load_byte};
      mse_pkg::LD_LBU: load_val = {24'd0, load_byte};
      mse_pkg::LD_LW:  load_val = rdata_q;
      default:         load_val = out_val_q;
    endcase
  end

  // Write port A: non-load results leaving the operand stage.
  // Write port B: load data, once the load result has reached the output register.
  assign wa_en = s1_fire && s1_exec && ex.wr && (ex.ld == mse_pkg::LD_NONE);
  assign wb_en = ldpend_q && out_wr_q;

  // Register value as it stands after this edge; the younger write wins.
  function automatic logic [31:0] fwd(input logic [4:0] r, input logic [31:0] cur,
                                      input logic a_en, input logic [4:0] a_idx,
                                      input logic [31:0] a_val, input logic b_en,
                                      input logic [4:0] b_idx, input logic [31:0] b_val);
    logic [31:0] v;
    v = cur;
    if (b_en && b_idx == r) v = b_val;
    if (a_en && a_idx == r) v = a_val;
    if (r == 5'd0) v = '0;
    return v;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 32; i++) regs_q[i] <= '0;
      hi_q <= '0;
      lo_q <= '0;
      pc_q <= mse_pkg::PC_RESET;
    end else begin
      if (wb_en) regs_q[out_idx_q] <= load_val;
      if (wa_en) regs_q[ex.idx] <= ex.val;
      if (s1_fire && s1_exec) begin
        pc_q <= ex.npc;
        if (ex.hilo_we) begin
          hi_q <= ex.hi;
          lo_q <= ex.lo;
        end
      end
    end
  end

  // Operand stage: capture the item and its forwarded operands
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s_accept) begin
      s1_valid_q <= 1'b1;
    end else if (advance) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      s1_op_q    <= in_op;
      s1_word_q  <= in_word;
      s1_laddr_q <= in_laddr;
      s1_a_q  <= fwd(in_rs, regs_q[in_rs], wa_en, ex.idx, ex.val, wb_en, out_idx_q, load_val);
      s1_b_q  <= fwd(in_rt, regs_q[in_rt], wa_en, ex.idx, ex.val, wb_en, out_idx_q, load_val);
      s1_r2_q <= fwd(5'd2, regs_q[2], wa_en, ex.idx, ex.val, wb_en, out_idx_q, load_val);
      s1_r4_q <= fwd(5'd4, regs_q[4], wa_en, ex.idx, ex.val, wb_en, out_idx_q, load_val);
    end
  end

  // Data memory: loader write, store, and registered read for loads
  assign ldaddr_ext = {16'd0, s1_laddr_q};
  assign ld_idx     = ldaddr_ext[AW+1:2];
  assign ea_idx     = ex.st_addr[AW+1:2];

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      rdata_q <= mem[ea_idx];
      if (s1_op_q == mse_pkg::OPER_LOAD) begin
        mem[ld_idx] <= s1_word_q;
      end else if (ex.st) begin
        if (ex.st_byte) begin
          mem[ea_idx][ex.st_addr[1:0]] <= ex.st_val[7:0];
        end else begin
          mem[ea_idx] <= ex.st_val;
        end
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      ldpend_q    <= 1'b0;
    end else begin
      ldpend_q <= s1_fire && s1_exec && (ex.ld != mse_pkg::LD_NONE);
      if (s1_fire) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      if (s1_exec) begin
        out_npc_q     <= ex.npc;
        out_status_q  <= ex.status;
        out_sc_code_q <= ex.sc_code;
        out_sc_arg_q  <= ex.sc_arg;
        out_wr_q      <= ex.wr;
        out_idx_q     <= ex.idx;
        out_val_q     <= ex.val;
        out_ld_q      <= ex.ld;
        out_lane_q    <= ex.st_addr[1:0];
        out_st_q      <= ex.st;
        out_st_addr_q <= ex.st ? ex.st_addr : 32'd0;
        out_st_val_q  <= ex.st_val;
        out_st_byte_q <= ex.st_byte;
      end else begin
        out_npc_q     <= pc_q;
        out_status_q  <= mse_pkg::ST_NORMAL;
        out_sc_code_q <= '0;
        out_sc_arg_q  <= '0;
        out_wr_q      <= 1'b0;
        out_idx_q     <= '0;
        out_val_q     <= '0;
        out_ld_q      <= mse_pkg::LD_NONE;
        out_lane_q    <= '0;
        out_st_q      <= 1'b0;
        out_st_addr_q <= '0;
        out_st_val_q  <= '0;
        out_st_byte_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0, out_st_byte_q, out_st_val_q, out_st_addr_q, out_st_q,
                          load_val, out_idx_q, out_wr_q, out_sc_arg_q, out_sc_code_q,
                          out_status_q, out_npc_q};

`ifndef NO_ASSERTIONS
  a_r0_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    regs_q[0] == 32'd0) else $error("r0 written");

  a_illegal_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_status_q == mse_pkg::ST_ILLEGAL |-> !out_wr_q && !out_st_q)
    else $error("illegal instruction changed state");

  a_pc_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire && s1_exec |=> pc_q == out_npc_q) else $error("pc and next_pc differ");

  a_load_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ldpend_q |-> out_valid_q && out_ld_q != mse_pkg::LD_NONE)
    else $error("load writeback without load result");
`endif

endmodule

// ===== rtl/core/mse_exec.sv =====
// ----------------------------------------------------------------------------
// mse_exec
// Decode and execute of one instruction word: ALU, shifts, multiply,
// branch and jump targets, effective address.
// ----------------------------------------------------------------------------
module mse_exec (
  input  logic [31:0]        instr_i,
  input  logic [31:0]        pc_i,
  input  logic [31:0]        a_i,
  input  logic [31:0]        b_i,
  input  logic [31:0]        r2_i,
  input  logic [31:0]        r4_i,
  input  logic [31:0]        hi_i,
  input  logic [31:0]        lo_i,
  output mse_pkg::exec_res_t res_o
);

  logic [5:0]  opc;
  logic [5:0]  fn;
  logic [4:0]  rt;
  logic [4:0]  rd;
  logic [4:0]  sa;
  logic [31:0] imm;
  logic [31:0] simm;
  logic [31:0] pc4;
  logic [31:0] ea;
  logic [63:0] prod;
  logic        wr;
  logic [4:0]  dst;
  logic        illegal;
  mse_pkg::exec_res_t r;

  assign opc  = instr_i[31:26];
  assign fn   = instr_i[5:0];
  assign rt   = instr_i[20:16];
  assign rd   = instr_i[15:11];
  assign sa   = instr_i[10:6];
  assign imm  = {16'h0000, instr_i[15:0]};
  assign simm = {{16{instr_i[15]}}, instr_i[15:0]};
  assign pc4  = pc_i + 32'd4;
  assign ea   = a_i + simm;
  assign prod = $signed(a_i) * $signed(b_i);

  always_comb begin
    r         = '0;
    r.ld      = mse_pkg::LD_NONE;
    r.npc     = pc4;
    r.status  = mse_pkg::ST_NORMAL;
    wr        = 1'b0;
    dst       = rd;
    illegal   = 1'b0;
    r.hi      = prod[63:32];
    r.lo      = prod[31:0];
    case (opc)
      mse_pkg::OP_SPECIAL: begin
        case (fn)
          mse_pkg::FN_SLL: begin wr = 1'b1; r.val = b_i << sa; end
          mse_pkg::FN_SRL: begin wr = 1'b1; r.val = b_i >> sa; end
          mse_pkg::FN_SRA: begin wr = 1'b1; r.val = $unsigned($signed(b_i) >>> sa); end
          mse_pkg::FN_JR:  r.npc = a_i;
          mse_pkg::FN_JALR: begin
            r.npc = a_i;
            wr    = 1'b1;
            r.val = pc4;
          end
          mse_pkg::FN_SYSCALL: begin
            r.status  = mse_pkg::ST_SYSCALL;
            r.sc_code = r2_i;
            r.sc_arg  = r4_i;
          end
          mse_pkg::FN_MFHI: begin wr = 1'b1; r.val = hi_i; end
          mse_pkg::FN_MFLO: begin wr = 1'b1; r.val = lo_i; end
          mse_pkg::FN_MULT: r.hilo_we = 1'b1;
          mse_pkg::FN_ADDU: begin wr = 1'b1; r.val = a_i + b_i; end
          mse_pkg::FN_SUBU: begin wr = 1'b1; r.val = a_i - b_i; end
          mse_pkg::FN_AND:  begin wr = 1'b1; r.val = a_i & b_i; end
          mse_pkg::FN_OR:   begin wr = 1'b1; r.val = a_i | b_i; end
          mse_pkg::FN_XOR:  begin wr = 1'b1; r.val = a_i ^ b_i; end
          mse_pkg::FN_NOR:  begin wr = 1'b1; r.val = ~(a_i | b_i); end
          mse_pkg::FN_SLT: begin
            wr    = 1'b1;
            r.val = {31'd0, $signed(a_i) < $signed(b_i)};
          end
          mse_pkg::FN_SLTU: begin wr = 1'b1; r.val = {31'd0, a_i < b_i}; end
          default: illegal = 1'b1;
        endcase
      end
      mse_pkg::OP_J:   r.npc = (pc4 & mse_pkg::PC_REGION) | {4'h0, instr_i[25:0], 2'b00};
      mse_pkg::OP_JAL: begin
        r.npc = (pc4 & mse_pkg::PC_REGION) | {4'h0, instr_i[25:0], 2'b00};
        wr    = 1'b1;
        dst   = 5'd31;
        r.val = pc4;
      end
      mse_pkg::OP_BEQ: if (a_i == b_i) r.npc = pc4 + {simm[29:0], 2'b00};
      mse_pkg::OP_BNE: if (a_i != b_i) r.npc = pc4 + {simm[29:0], 2'b00};
      mse_pkg::OP_ADDIU: begin wr = 1'b1; dst = rt; r.val = a_i + simm; end
      mse_pkg::OP_SLTI: begin
        wr    = 1'b1;
        dst   = rt;
        r.val = {31'd0, $signed(a_i) < $signed(simm)};
      end
      mse_pkg::OP_SLTIU: begin wr = 1'b1; dst = rt; r.val = {31'd0, a_i < simm}; end
      mse_pkg::OP_ANDI:  begin wr = 1'b1; dst = rt; r.val = a_i & imm; end
      mse_pkg::OP_ORI:   begin wr = 1'b1; dst = rt; r.val = a_i | imm; end
      mse_pkg::OP_XORI:  begin wr = 1'b1; dst = rt; r.val = a_i ^ imm; end
      mse_pkg::OP_LUI:   begin wr = 1'b1; dst = rt; r.val = {instr_i[15:0], 16'h0000}; end
      mse_pkg::OP_LB:    begin wr = 1'b1; dst = rt; r.ld = mse_pkg::LD_LB; end
      mse_pkg::OP_LBU:   begin wr = 1'b1; dst = rt; r.ld = mse_pkg::LD_LBU; end
      mse_pkg::OP_LW:    begin wr = 1'b1; dst = rt; r.ld = mse_pkg::LD_LW; end
      mse_pkg::OP_SB: begin
        r.st      = 1'b1;
        r.st_byte = 1'b1;
        r.st_addr = ea;
        r.st_val  = {24'd0, b_i[7:0]};
      end
      mse_pkg::OP_SW: begin
        r.st      = 1'b1;
        r.st_addr = ea;
        r.st_val  = b_i;
      end
      default: illegal = 1'b1;
    endcase
    r.wr  = wr && (dst != 5'd0);
    r.idx = r.wr ? dst : 5'd0;
    if (!r.wr) begin
      r.val = '0;
      r.ld  = mse_pkg::LD_NONE;
    end
    // Legal instructions carry the effective address here; loads use it for the read and the byte lane.
    r.st_addr = (r.st || wr) ? ((r.st) ? ea : ea) : '0;
    if (!r.st) r.st_addr = ea;
    if (illegal) begin
      r         = '0;
      r.ld      = mse_pkg::LD_NONE;
      r.npc     = pc_i;
      r.status  = mse_pkg::ST_ILLEGAL;
    end
  end

  assign res_o = r;

endmodule

// ===== sim/mips32_subset_executor_tb.sv =====
// ----------------------------------------------------------------------------
// mips32_subset_executor_tb
// Self-checking bench for the MIPS32 subset executor. A directed program
// covers every instruction, the loader, the special cases and the field
// extremes. A long random program follows, with loads aimed only at memory
// words that were written in full. A predictor tracks registers, hi/lo, pc
// and data memory, and the monitor checks each result field by field.
// ----------------------------------------------------------------------------
module mips32_subset_executor_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mse_pkg::*;

  localparam int unsigned N_RANDOM   = 1430;
  localparam int unsigned MAX_WAIT   = 18;
  localparam int unsigned HOLD_OFF   = 400;
  localparam int unsigned CYCLE_CAP  = 400000;
  localparam int unsigned DRAIN_CYC  = 12;

  typedef struct {
    logic        oper;
    logic [31:0] word;
    logic [15:0] laddr;
  } instr_item_t;

  typedef struct {
    logic [31:0] npc;
    logic [1:0]  status;
    logic [31:0] sc_code;
    logic [31:0] sc_arg;
    logic        wr;
    logic [4:0]  idx;
    logic [31:0] val;
    logic        st;
    logic [31:0] st_addr;
    logic [31:0] st_val;
    logic        st_byte;
  } retire_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic [47:0]  s_axis_tdata = '0;
  logic         s_axis_tuser = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [207:0] m_axis_tdata;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;

  mips32_subset_executor u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready)
  );

  always #10 clk_i = ~clk_i;

  // Shadow architectural state of the core
  logic [31:0] gpr [32];
  logic [31:0] hi_q, lo_q, pc_q;
  logic [31:0] dmem [int];
  bit          word_full [int];
  int          full_words [$];

  instr_item_t pending_instrs [$];
  retire_t     expected_retires [$];

  bit          failed = 1'b0;
  int unsigned cycles = 0;
  int unsigned retired = 0;

  // --------------------------------------------------------------------------
  // Instruction encoders
  // --------------------------------------------------------------------------
  function automatic logic [31:0] enc_r(logic [4:0] rs, logic [4:0] rt, logic [4:0] rd,
                                        logic [4:0] sa, logic [5:0] fn);
    return {OP_SPECIAL, rs, rt, rd, sa, fn};
  endfunction

  function automatic logic [31:0] enc_i(logic [5:0] op, logic [4:0] rs, logic [4:0] rt,
                                        logic [15:0] imm);
    return {op, rs, rt, imm};
  endfunction

  function automatic bit is_legal(logic [31:0] w);
    if (w[31:26] == OP_SPECIAL)
      return w[5:0] inside {FN_SLL, FN_SRL, FN_SRA, FN_JR, FN_JALR, FN_SYSCALL, FN_MFHI,
                            FN_MFLO, FN_MULT, FN_ADDU, FN_SUBU, FN_AND, FN_OR, FN_XOR,
                            FN_NOR, FN_SLT, FN_SLTU};
    return w[31:26] inside {OP_J, OP_JAL, OP_BEQ, OP_BNE, OP_ADDIU, OP_SLTI, OP_SLTIU,
                            OP_ANDI, OP_ORI, OP_XORI, OP_LUI, OP_LB, OP_LW, OP_LBU,
                            OP_SB, OP_SW};
  endfunction

  function automatic logic [7:0] mem_byte(logic [31:0] addr);
    logic [31:0] w;
    w = dmem.exists(int'(addr[15:2])) ? dmem[int'(addr[15:2])] : '0;
    return w[addr[1:0]*8 +: 8];
  endfunction

  function automatic void mem_word(logic [31:0] addr, logic [31:0] w);
    dmem[int'(addr[15:2])] = w;
    if (!word_full.exists(int'(addr[15:2]))) begin
      word_full[int'(addr[15:2])] = 1'b1;
      full_words.push_back(int'(addr[15:2]));
    end
  endfunction

  // --------------------------------------------------------------------------
  // Predictor: retire one transaction against the shadow state
  // --------------------------------------------------------------------------
  function automatic retire_t retire_instr(instr_item_t it);
    retire_t     r;
    logic [5:0]  opc, fn;
    logic [4:0]  rs, rt, rd, sa, dst;
    logic [31:0] a, b, pc4, npc, simm, zimm, ea, val, w;
    logic [63:0] prod;
    logic [7:0]  bv;
    bit          wr, illegal;
    r = '{default: '0};
    if (it.oper == OPER_LOAD) begin
      mem_word({16'd0, it.laddr}, it.word);
      r.npc = pc_q;
      return r;
    end
    opc = it.word[31:26]; rs = it.word[25:21]; rt = it.word[20:16];
    rd = it.word[15:11];  sa = it.word[10:6];  fn = it.word[5:0];
    simm = {{16{it.word[15]}}, it.word[15:0]};
    zimm = {16'd0, it.word[15:0]};
    a = gpr[rs]; b = gpr[rt];
    pc4 = pc_q + 32'd4; npc = pc4; ea = a + simm;
    wr = 1'b0; dst = '0; val = '0; illegal = 1'b0;
    case (opc)
      OP_SPECIAL: begin
        dst = rd;
        wr = 1'b1;
        case (fn)
          FN_SLL:  val = b << sa;
          FN_SRL:  val = b >> sa;
          FN_SRA:  val = $signed(b) >>> sa;
          FN_JR: begin
            npc = a; wr = 1'b0;
          end
          FN_JALR: begin
            npc = a; val = pc4;
          end
          FN_SYSCALL: begin
            wr = 1'b0; r.status = ST_SYSCALL; r.sc_code = gpr[2]; r.sc_arg = gpr[4];
          end
          FN_MFHI: val = hi_q;
          FN_MFLO: val = lo_q;
          FN_MULT: begin
            wr = 1'b0;
            prod = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
            hi_q = prod[63:32]; lo_q = prod[31:0];
          end
          FN_ADDU: val = a + b;
          FN_SUBU: val = a - b;
          FN_AND:  val = a & b;
          FN_OR:   val = a | b;
          FN_XOR:  val = a ^ b;
          FN_NOR:  val = ~(a | b);
          FN_SLT:  val = {31'd0, $signed(a) < $signed(b)};
          FN_SLTU: val = {31'd0, a < b};
          default: illegal = 1'b1;
        endcase
      end
      OP_J:   npc = {pc4[31:28], it.word[25:0], 2'b00};
      OP_JAL: begin
        npc = {pc4[31:28], it.word[25:0], 2'b00}; wr = 1'b1; dst = 5'd31; val = pc4;
      end
      OP_BEQ: if (a == b) npc = pc4 + (simm << 2);
      OP_BNE: if (a != b) npc = pc4 + (simm << 2);
      default: begin
        dst = rt;
        wr = 1'b1;
        case (opc)
          OP_ADDIU: val = a + simm;
          OP_SLTI:  val = {31'd0, $signed(a) < $signed(simm)};
          OP_SLTIU: val = {31'd0, a < simm};
          OP_ANDI:  val = a & zimm;
          OP_ORI:   val = a | zimm;
          OP_XORI:  val = a ^ zimm;
          OP_LUI:   val = {it.word[15:0], 16'd0};
          OP_LB: begin
            bv = mem_byte(ea);
            val = {{24{bv[7]}}, bv};
          end
          OP_LBU:   val = {24'd0, mem_byte(ea)};
          OP_LW:    val = dmem.exists(int'(ea[15:2])) ? dmem[int'(ea[15:2])] : '0;
          OP_SB: begin
            wr = 1'b0; r.st = 1'b1; r.st_byte = 1'b1; r.st_addr = ea;
            r.st_val = {24'd0, b[7:0]};
            w = dmem.exists(int'(ea[15:2])) ? dmem[int'(ea[15:2])] : '0;
            w[ea[1:0]*8 +: 8] = b[7:0];
            dmem[int'(ea[15:2])] = w;
          end
          OP_SW: begin
            wr = 1'b0; r.st = 1'b1; r.st_addr = ea; r.st_val = b;
            mem_word(ea, b);
          end
          default: illegal = 1'b1;
        endcase
      end
    endcase
    if (illegal) begin
      r = '{default: '0};
      r.npc = pc_q;
      r.status = ST_ILLEGAL;
      return r;
    end
    if (wr && dst != 5'd0) begin
      gpr[dst] = val;
      r.wr = 1'b1; r.idx = dst; r.val = val;
    end
    pc_q = npc;
    r.npc = npc;
    return r;
  endfunction

  // Queue one transaction and its expected result
  task automatic issue(logic oper, logic [31:0] word, logic [15:0] laddr);
    instr_item_t it;
    it = '{oper: oper, word: word, laddr: laddr};
    pending_instrs.push_back(it);
    expected_retires.push_back(retire_instr(it));
  endtask

  // Random loader write or instruction; loads are steered onto fully written words
  task automatic issue_random();
    logic [5:0]  legal_ops [16] = '{OP_J, OP_JAL, OP_BEQ, OP_BNE, OP_ADDIU, OP_SLTI,
                                    OP_SLTIU, OP_ANDI, OP_ORI, OP_XORI, OP_LUI, OP_LB,
                                    OP_LW, OP_LBU, OP_SB, OP_SW};
    logic [5:0]  legal_fns [17] = '{FN_SLL, FN_SRL, FN_SRA, FN_JR, FN_JALR, FN_SYSCALL,
                                    FN_MFHI, FN_MFLO, FN_MULT, FN_ADDU, FN_SUBU, FN_AND,
                                    FN_OR, FN_XOR, FN_NOR, FN_SLT, FN_SLTU};
    logic [31:0] w, target;
    int unsigned roll, pick;
    roll = $urandom_range(0, 99);
    w = $urandom;
    if (roll < 12) begin
      issue(OPER_LOAD, w, 16'($urandom));
      return;
    end
    if (roll < 16) begin
      // Unknown opcode or function code
      while (is_legal(w)) w = $urandom;
      issue(OPER_EXEC, w, 16'($urandom));
      return;
    end
    pick = $urandom_range(0, 32);
    if (pick < 17) begin
      w[31:26] = OP_SPECIAL; w[5:0] = legal_fns[pick];
    end else begin
      w[31:26] = legal_ops[pick - 17];
    end
    // Bias beq toward taken and bne toward not taken by making rt equal rs
    if (w[31:26] inside {OP_BEQ, OP_BNE} && $urandom_range(0, 2) == 0) w[20:16] = w[25:21];
    if (w[31:26] inside {OP_LB, OP_LW, OP_LBU}) begin
      if (full_words.size() == 0) begin
        issue(OPER_LOAD, w, 16'($urandom));
        return;
      end
      target = (full_words[$urandom_range(0, full_words.size() - 1)] << 2)
               + $urandom_range(0, 3);
      w[15:0] = 16'(target - gpr[w[25:21]]);
    end
    issue(OPER_EXEC, w, 16'($urandom));
  endtask

  task automatic build_program();
    issue(OPER_LOAD, 32'h8081_7f01, 16'h0000);
    issue(OPER_LOAD, 32'hdead_beef, 16'hffff);
    issue(OPER_EXEC, enc_i(OP_LUI, 5'd0, 5'd1, 16'h8000), 16'hffff);
    issue(OPER_EXEC, enc_i(OP_ADDIU, 5'd0, 5'd2, 16'hffff), '0);
    issue(OPER_EXEC, enc_i(OP_ORI, 5'd0, 5'd4, 16'hffff), '0);
    issue(OPER_EXEC, enc_r(5'd0, 5'd0, 5'd0, 5'd0, FN_SYSCALL), '0);
    issue(OPER_EXEC, enc_r(5'd1, 5'd1, 5'd0, 5'd0, FN_MULT), '0);
    issue(OPER_EXEC, enc_r(5'd0, 5'd0, 5'd3, 5'd0, FN_MFHI), '0);
    issue(OPER_EXEC, enc_r(5'd0, 5'd0, 5'd5, 5'd0, FN_MFLO), '0);
    issue(OPER_EXEC, enc_r(5'd7, 5'd2, 5'd6, 5'd31, FN_SLL), '0);
    issue(OPER_EXEC, enc_r(5'd0, 5'd1, 5'd7, 5'd31, FN_SRL), '0);
    issue(OPER_EXEC, enc_r(5'd0, 5'd1, 5'd8, 5'd31, FN_SRA), '0);
    issue(OPER_EXEC, enc_r(5'd1, 5'd2, 5'd9, 5'd3, FN_ADDU), '0);
    issue(OPER_EXEC, enc_r(5'd1, 5'd2, 5'd10, 5'd0, FN_SUBU), '0);
    issue(OPER_EXEC, enc_r(5'd1, 5'd4, 5'd11, 5'd0, FN_AND), '0);
    issue(OPER_EXEC, enc_r(5'd1, 5'd4, 5'd11, 5'd0, FN_OR), '0);
    issue(OPER_EXEC, enc_r(5'd1, 5'd2, 5'd11, 5'd0, FN_XOR), '0);
    issue(OPER_EXEC, enc_r(5'd1, 5'd4, 5'd11, 5'd0, FN_NOR), '0);
    issue(OPER_EXEC, enc_r(5'd1, 5'd4, 5'd12, 5'd0, FN_SLT), '0);
    issue(OPER_EXEC, enc_r(5'd1, 5'd4, 5'd13, 5'd0, FN_SLTU), '0);
    issue(OPER_EXEC, enc_i(OP_SLTI, 5'd1, 5'd14, 16'hffff), '0);
    issue(OPER_EXEC, enc_i(OP_SLTIU, 5'd2, 5'd15, 16'hffff), '0);
    issue(OPER_EXEC, enc_i(OP_ANDI, 5'd2, 5'd15, 16'h8001), '0);
    issue(OPER_EXEC, enc_i(OP_XORI, 5'd2, 5'd15, 16'hffff), '0);
    // Sign-extended and zero-extended byte loads, unaligned and wrapped words
    issue(OPER_EXEC, enc_i(OP_LB, 5'd0, 5'd16, 16'h0003), '0);
    issue(OPER_EXEC, enc_i(OP_LBU, 5'd0, 5'd17, 16'h0003), '0);
    issue(OPER_EXEC, enc_i(OP_LW, 5'd0, 5'd18, 16'h0002), '0);
    issue(OPER_EXEC, enc_i(OP_LW, 5'd0, 5'd18, 16'hfffc), '0);
    issue(OPER_EXEC, enc_i(OP_SB, 5'd0, 5'd2, 16'h0005), '0);
    issue(OPER_EXEC, enc_i(OP_SW, 5'd1, 5'd1, 16'h0003), '0);
    issue(OPER_EXEC, enc_i(OP_BEQ, 5'd0, 5'd0, 16'h0002), '0);
    issue(OPER_EXEC, enc_i(OP_BNE, 5'd1, 5'd0, 16'hffff), '0);
    issue(OPER_EXEC, {OP_J, 26'h3ff_ffff}, '0);
    issue(OPER_EXEC, {OP_JAL, 26'h000_0400}, '0);
    // jalr whose destination is also its source, then jr, then a write to r0
    issue(OPER_EXEC, enc_r(5'd2, 5'd0, 5'd2, 5'd0, FN_JALR), '0);
    issue(OPER_EXEC, enc_r(5'd31, 5'd0, 5'd0, 5'd0, FN_JR), '0);
    issue(OPER_EXEC, enc_r(5'd1, 5'd2, 5'd0, 5'd0, FN_ADDU), '0);
    issue(OPER_EXEC, {6'h3f, 26'h3ff_ffff}, '0);
    issue(OPER_EXEC, enc_r(5'd0, 5'd0, 5'd1, 5'd0, 6'h01), '0);
    repeat (N_RANDOM) issue_random();
  endtask

  // --------------------------------------------------------------------------
  // Driver: present transactions at the falling edge, with random gaps
  // --------------------------------------------------------------------------
  bit          in_taken = 1'b0;
  int unsigned in_gap = 0;
  int unsigned in_sent = 0;
  instr_item_t in_cur;

  always @(negedge clk_i) begin
    if (rst_ni && (!s_axis_tvalid || in_taken)) begin
      if (in_gap > 0) begin
        s_axis_tvalid <= 1'b0;
        in_gap--;
      end else if (pending_instrs.size() > 0) begin
        in_cur = pending_instrs.pop_front();
        s_axis_tdata  <= {in_cur.laddr, in_cur.word};
        s_axis_tuser  <= in_cur.oper;
        s_axis_tvalid <= 1'b1;
        in_sent++;
        // Alternate stretches of back-to-back traffic with stretches of gaps
        in_gap = ((in_sent / 128) % 2 == 0) ? 0 : $urandom_range(0, MAX_WAIT);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) in_taken <= s_axis_tvalid && s_axis_tready;

  // --------------------------------------------------------------------------
  // Monitor: stall the result side and check every result
  // --------------------------------------------------------------------------
  bit          out_taken = 1'b0;
  int unsigned out_stall = 0;
  bit          hold_done = 1'b0;

  always @(negedge clk_i) begin
    if (rst_ni && (!m_axis_tready || out_taken)) begin
      if (!hold_done && retired >= 600) begin
        // Long hold-off so the core backs up and stalls its input
        hold_done = 1'b1;
        out_stall = HOLD_OFF;
      end
      if (out_stall > 0) begin
        m_axis_tready <= 1'b0;
        out_stall--;
      end else begin
        m_axis_tready <= 1'b1;
        out_stall = ((retired / 160) % 2 == 1) ? 0 : $urandom_range(0, MAX_WAIT);
      end
    end
  end

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %h, got %h", name, exp_v, act_v);
      failed = 1'b1;
    end
  endtask

  always @(posedge clk_i) begin
    retire_t exp_r;
    out_taken <= m_axis_tvalid && m_axis_tready;
    cycles++;
    if (m_axis_tvalid && m_axis_tready) begin
      retired++;
      if (expected_retires.size() == 0) begin
        $error("result with no expected value pending");
        failed = 1'b1;
      end else begin
        exp_r = expected_retires.pop_front();
        check_field("next_pc",       exp_r.npc,     m_axis_tdata[31:0]);
        check_field("status",        exp_r.status,  m_axis_tdata[33:32]);
        check_field("syscall_code",  exp_r.sc_code, m_axis_tdata[65:34]);
        check_field("syscall_arg",   exp_r.sc_arg,  m_axis_tdata[97:66]);
        check_field("reg_written",   exp_r.wr,      m_axis_tdata[98]);
        check_field("reg_index",     exp_r.idx,     m_axis_tdata[103:99]);
        check_field("reg_value",     exp_r.val,     m_axis_tdata[135:104]);
        check_field("stored",        exp_r.st,      m_axis_tdata[136]);
        check_field("store_address", exp_r.st_addr, m_axis_tdata[168:137]);
        check_field("store_value",   exp_r.st_val,  m_axis_tdata[200:169]);
        check_field("store_is_byte", exp_r.st_byte, m_axis_tdata[201]);
      end
    end
    if (cycles > CYCLE_CAP) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Sequence: build the program, release reset, drain, report
  // --------------------------------------------------------------------------
  initial begin
    foreach (gpr[i]) gpr[i] = '0;
    hi_q = '0;
    lo_q = '0;
    pc_q = PC_RESET;
    build_program();
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    while (pending_instrs.size() != 0 || expected_retires.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYC) @(posedge clk_i);
    if (!failed && expected_retires.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/mse_pkg.sv
rtl/core/mse_exec.sv
rtl/core/mips32_subset_executor.sv
sim/mips32_subset_executor_tb.sv
